/* rtl/ldm_pkg.sv */
package ldm_pkg;

    // Intermediate values are signed with 28 fraction bits and a magnitude
    // limited to 2^60 - 1, so 61 bits hold every one of them.
    localparam int VAL_W = 61;
    localparam int MAG_W = VAL_W - 1;

    // Register latency of the pipelined saturating multiplier.
    localparam int MUL_LAT = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_NEW_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_INV_FOCAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIG_CENTER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIG_FOCAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL    = 3'd6;

    // Reset values: unit reciprocal focal lengths (Q8.24) and unit focal
    // lengths (Q16.16), everything else zero.
    localparam logic [CFG_DATA_W-1:0] NEW_INV_FOCAL_RST = 64'h0100_0000_0100_0000;
    localparam logic [CFG_DATA_W-1:0] ORIG_FOCAL_RST    = 64'h0001_0000_0001_0000;

    // Saturation limits.
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {MAG_W{1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = -VAL_MAX;
    localparam logic signed [VAL_W:0]   SUM_MAX = {2'b00, {MAG_W{1'b1}}};
    localparam logic signed [VAL_W:0]   SUM_MIN = -SUM_MAX;

    // One value in flight together with the saturation flags of every step
    // that fed it.
    typedef struct packed {
        logic                    flag;
        logic signed [VAL_W-1:0] val;
    } fx_t;

    localparam fx_t ONE_Q28 = '{flag: 1'b0, val: 61'sh000_0000_1000_0000};

    // Sign-extend a signed 32-bit register field.
    function automatic fx_t from_s32(input logic [31:0] x);
        fx_t r;
        r.flag = 1'b0;
        r.val  = {{(VAL_W-32){x[31]}}, x};
        return r;
    endfunction

    // Zero-extend an unsigned 32-bit register field.
    function automatic fx_t from_u32(input logic [31:0] x);
        fx_t r;
        r.flag = 1'b0;
        r.val  = {{(VAL_W-32){1'b0}}, x};
        return r;
    endfunction

    // Saturating add; the result flag collects both inputs and any clipping.
    function automatic fx_t sat_add(input fx_t a, input fx_t b);
        logic signed [VAL_W:0] s;
        fx_t                   r;
        s = $signed({a.val[VAL_W-1], a.val}) + $signed({b.val[VAL_W-1], b.val});
        r.flag = a.flag | b.flag;
        r.val  = s[VAL_W-1:0];
        if (s > SUM_MAX)
        begin
            r.val  = VAL_MAX;
            r.flag = 1'b1;
        end
        else if (s < SUM_MIN)
        begin
            r.val  = VAL_MIN;
            r.flag = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/ldm_delay.sv */
module ldm_delay #(
    parameter int W     = 62,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [0:DEPTH-1];

    // Shift line that moves only when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

/* rtl/ldm_mul.sv */
module ldm_mul #(
    parameter int SHIFT = 28
) (
    input  logic          clk,
    input  logic          en,
    input  ldm_pkg::fx_t  a,
    input  ldm_pkg::fx_t  b,
    output ldm_pkg::fx_t  p
);
    import ldm_pkg::*;

    localparam int HALF_W = MAG_W / 2;
    localparam int PROD_W = 2 * MAG_W;
    localparam logic [MAG_W:0] ROUND = (MAG_W + 1)'(1) << (SHIFT - 1);

    logic [VAL_W-1:0] abs_a;
    logic [VAL_W-1:0] abs_b;

    // Stage 1: sign and magnitudes.
    logic             neg1_reg;
    logic             flag1_reg;
    logic [MAG_W-1:0] ma_reg;
    logic [MAG_W-1:0] mb_reg;

    // Stage 2: four partial products of 30 by 30 bits.
    logic             neg2_reg;
    logic             flag2_reg;
    logic [MAG_W-1:0] ll_reg;
    logic [MAG_W-1:0] lh_reg;
    logic [MAG_W-1:0] hl_reg;
    logic [MAG_W-1:0] hh_reg;

    // Stage 3: middle sum and rounded low part.
    logic             neg3_reg;
    logic             flag3_reg;
    logic [MAG_W-1:0] hh3_reg;
    logic [MAG_W:0]   mid_reg;
    logic [MAG_W:0]   lo_reg;

    // Stage 4: full rounded product magnitude.
    logic              neg4_reg;
    logic              flag4_reg;
    logic [PROD_W-1:0] full_reg;

    // Stage 5: shift, saturate and restore the sign.
    logic              sat;
    logic [MAG_W-1:0]  mag;
    fx_t               p_next;
    fx_t               p_reg;

    assign abs_a = a.val[VAL_W-1] ? (VAL_W'(0) - a.val) : a.val;
    assign abs_b = b.val[VAL_W-1] ? (VAL_W'(0) - b.val) : b.val;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= a.val[VAL_W-1] ^ b.val[VAL_W-1];
            flag1_reg <= a.flag | b.flag;
            ma_reg    <= abs_a[MAG_W-1:0];
            mb_reg    <= abs_b[MAG_W-1:0];

            neg2_reg  <= neg1_reg;
            flag2_reg <= flag1_reg;
            ll_reg    <= ma_reg[HALF_W-1:0] * mb_reg[HALF_W-1:0];
            lh_reg    <= ma_reg[HALF_W-1:0] * mb_reg[MAG_W-1:HALF_W];
            hl_reg    <= ma_reg[MAG_W-1:HALF_W] * mb_reg[HALF_W-1:0];
            hh_reg    <= ma_reg[MAG_W-1:HALF_W] * mb_reg[MAG_W-1:HALF_W];

            neg3_reg  <= neg2_reg;
            flag3_reg <= flag2_reg;
            hh3_reg   <= hh_reg;
            mid_reg   <= {1'b0, lh_reg} + {1'b0, hl_reg};
            lo_reg    <= {1'b0, ll_reg} + ROUND;

            neg4_reg  <= neg3_reg;
            flag4_reg <= flag3_reg;
            full_reg  <= {hh3_reg, {MAG_W{1'b0}}}
                       + {{(PROD_W-MAG_W-1-HALF_W){1'b0}}, mid_reg, {HALF_W{1'b0}}}
                       + {{(PROD_W-MAG_W-1){1'b0}}, lo_reg};

            p_reg     <= p_next;
        end
    end

    // Any bit above the 60-bit magnitude after the shift means saturation.
    always_comb
    begin
        sat = |full_reg[PROD_W-1:SHIFT+MAG_W];
        mag = sat ? {MAG_W{1'b1}} : full_reg[SHIFT+MAG_W-1:SHIFT];
        p_next.flag = flag4_reg | sat;
        p_next.val  = neg4_reg ? (VAL_W'(0) - {1'b0, mag}) : {1'b0, mag};
    end

    assign p = p_reg;

endmodule

/* rtl/lens_undistort_map.sv */
// Brown-Conrady lens distortion map. For each undistorted output pixel
// (pixel_x, pixel_y) the block returns the source point (map_x, map_y) in
// the distorted image as signed Q16.16, plus clipped when any step saturated.
//
// Channels: the pixel input and the result output each use valid/ready; a
// transfer happens on a rising edge with valid and ready both high. The
// configuration channel (cfg_valid, cfg_index, cfg_data) is always ready and
// must only be written while no pixel is in flight. Index 7 is ignored.
//
// Throughput is one pixel per cycle while the pipeline is not held. From the
// input transfer to out_valid a pixel passes a chain of seven pipelined
// multipliers (each built from 30x30 partial products) and registered saturating adds.
//
// When the receiver stalls, the pipeline keeps running until a one-entry skid
// buffer behind the output register is filled; only then does in_ready drop
// and every stage hold. Nothing is dropped or duplicated.
//
// Reset empties the pipeline and the output and returns the configuration
// registers to unit focal lengths and zero centers and coefficients.
module lens_undistort_map #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ldm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ldm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [11:0]                        pixel_x,
    input  logic [11:0]                        pixel_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 map_x,
    output logic signed [31:0]                 map_y,
    output logic                               clipped
);
    import ldm_pkg::*;

    // Stage at whose register each value first appears.
    localparam int S_IN   = 1;
    localparam int S_XU   = S_IN + MUL_LAT;
    localparam int S_SQ   = S_XU + MUL_LAT;
    localparam int S_R2   = S_SQ + 1;
    localparam int S_RX   = S_R2 + 1;
    localparam int S_K3   = S_R2 + MUL_LAT;
    localparam int S_H1   = S_K3 + 1;
    localparam int S_M2   = S_H1 + MUL_LAT;
    localparam int S_H2   = S_M2 + 1;
    localparam int S_M3   = S_H2 + MUL_LAT;
    localparam int S_RAD  = S_M3 + 1;
    localparam int S_XT   = S_RAD + MUL_LAT;
    localparam int S_D1   = S_XT + 1;
    localparam int S_D2   = S_D1 + 1;
    localparam int S_PJ   = S_D2 + MUL_LAT;
    localparam int S_OC   = S_PJ + 1;
    localparam int S_LAST = S_OC + 1;
    localparam int S_TP1  = S_R2 + MUL_LAT;
    localparam int S_TP2  = S_RX + MUL_LAT;
    localparam int FX_W   = $bits(fx_t);

    localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
    localparam logic [16:0] MAX_H17 = 17'(MAX_HEIGHT);
    localparam logic [11:0] LAST_COL = 12'(MAX_WIDTH - 1);
    localparam logic [11:0] LAST_ROW = 12'(MAX_HEIGHT - 1);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        c;
    } res_t;

    // Configuration registers.
    logic [63:0] new_center_reg;
    logic [63:0] new_inv_focal_reg;
    logic [63:0] orig_center_reg;
    logic [63:0] orig_focal_reg;
    logic [63:0] radial_low_reg;
    logic [31:0] radial_high_reg;
    logic [63:0] tangential_reg;

    // Pipeline control.
    logic              adv;
    logic [S_LAST:1]   v_reg;

    // Datapath.
    logic [11:0]        px_c;
    logic [11:0]        py_c;
    logic signed [33:0] dx34;
    logic signed [33:0] dy34;
    fx_t dx_reg, dy_reg;
    fx_t xu, yu, x2, y2, xy;
    fx_t r2_reg, xy2_reg, x2d_reg, y2d_reg;
    fx_t rx_reg, ry_reg;
    fx_t k3r2, h1_reg, m2, h2_reg, m3, rad_reg;
    fx_t r2_a, r2_b;
    fx_t p1xy, p2xy, p2rx, p1ry;
    fx_t p1xy_d, p2xy_d, p2rx_d, p1ry_d;
    fx_t xu_d, yu_d, mxt, myt;
    fx_t xd1_reg, yd1_reg, xd_reg, yd_reg;
    fx_t pxm, pym, mx_reg, my_reg;
    res_t last_next, last_reg;

    // Output register and skid buffer.
    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_center_reg    <= '0;
            new_inv_focal_reg <= NEW_INV_FOCAL_RST;
            orig_center_reg   <= '0;
            orig_focal_reg    <= ORIG_FOCAL_RST;
            radial_low_reg    <= '0;
            radial_high_reg   <= '0;
            tangential_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NEW_CENTER:    new_center_reg    <= cfg_data;
                REG_NEW_INV_FOCAL: new_inv_focal_reg <= cfg_data;
                REG_ORIG_CENTER:   orig_center_reg   <= cfg_data;
                REG_ORIG_FOCAL:    orig_focal_reg    <= cfg_data;
                REG_RADIAL_LOW:    radial_low_reg    <= cfg_data;
                REG_RADIAL_HIGH:   radial_high_reg   <= cfg_data[31:0];
                REG_TANGENTIAL:    tangential_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The whole pipeline advances unless the skid buffer is occupied.
    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[S_LAST-1:1], in_valid};
        end
    end

    // Input stage: clamp to the frame and subtract the new principal point.
    always_comb
    begin
        px_c = ({5'b0, pixel_x} >= MAX_W17) ? LAST_COL : pixel_x;
        py_c = ({5'b0, pixel_y} >= MAX_H17) ? LAST_ROW : pixel_y;
        dx34 = $signed({6'b0, px_c, 16'b0})
             - $signed({{2{new_center_reg[63]}}, new_center_reg[63:32]});
        dy34 = $signed({6'b0, py_c, 16'b0})
             - $signed({{2{new_center_reg[31]}}, new_center_reg[31:0]});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg.flag <= 1'b0;
            dx_reg.val  <= {{(VAL_W-34){dx34[33]}}, dx34};
            dy_reg.flag <= 1'b0;
            dy_reg.val  <= {{(VAL_W-34){dy34[33]}}, dy34};
        end
    end

    // Normalize with the reciprocal new focal lengths (Q.40 down to Q.28).
    ldm_mul #(.SHIFT(12)) u_mul_xu (
        .clk(clk), .en(adv), .a(dx_reg), .b(from_u32(new_inv_focal_reg[63:32])), .p(xu)
    );
    ldm_mul #(.SHIFT(12)) u_mul_yu (
        .clk(clk), .en(adv), .a(dy_reg), .b(from_u32(new_inv_focal_reg[31:0])), .p(yu)
    );

    // Squares and cross product.
    ldm_mul #(.SHIFT(28)) u_mul_x2 (.clk(clk), .en(adv), .a(xu), .b(xu), .p(x2));
    ldm_mul #(.SHIFT(28)) u_mul_y2 (.clk(clk), .en(adv), .a(yu), .b(yu), .p(y2));
    ldm_mul #(.SHIFT(28)) u_mul_xy (.clk(clk), .en(adv), .a(xu), .b(yu), .p(xy));

    // Radius squared, doubled terms, and the tangential sums.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_reg  <= sat_add(x2, y2);
            xy2_reg <= sat_add(xy, xy);
            x2d_reg <= sat_add(x2, x2);
            y2d_reg <= sat_add(y2, y2);
            rx_reg  <= sat_add(r2_reg, x2d_reg);
            ry_reg  <= sat_add(r2_reg, y2d_reg);
        end
    end

    // Radial factor by Horner's rule: 1 + r2*(k1 + r2*(k2 + r2*k3)).
    ldm_mul #(.SHIFT(28)) u_mul_k3 (
        .clk(clk), .en(adv), .a(from_s32(radial_high_reg)), .b(r2_reg), .p(k3r2)
    );

    ldm_delay #(.W(FX_W), .DEPTH(S_H1 - S_R2)) u_dly_r2a (
        .clk(clk), .en(adv), .d(r2_reg), .q(r2_a)
    );
    ldm_delay #(.W(FX_W), .DEPTH(S_H2 - S_H1)) u_dly_r2b (
        .clk(clk), .en(adv), .d(r2_a), .q(r2_b)
    );

    ldm_mul #(.SHIFT(28)) u_mul_h1 (.clk(clk), .en(adv), .a(h1_reg), .b(r2_a), .p(m2));
    ldm_mul #(.SHIFT(28)) u_mul_h2 (.clk(clk), .en(adv), .a(h2_reg), .b(r2_b), .p(m3));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_reg  <= sat_add(from_s32(radial_low_reg[31:0]), k3r2);
            h2_reg  <= sat_add(from_s32(radial_low_reg[63:32]), m2);
            rad_reg <= sat_add(ONE_Q28, m3);
        end
    end

    // Tangential products.
    ldm_mul #(.SHIFT(28)) u_mul_p1xy (
        .clk(clk), .en(adv), .a(from_s32(tangential_reg[63:32])), .b(xy2_reg), .p(p1xy)
    );
    ldm_mul #(.SHIFT(28)) u_mul_p2xy (
        .clk(clk), .en(adv), .a(from_s32(tangential_reg[31:0])), .b(xy2_reg), .p(p2xy)
    );
    ldm_mul #(.SHIFT(28)) u_mul_p2rx (
        .clk(clk), .en(adv), .a(from_s32(tangential_reg[31:0])), .b(rx_reg), .p(p2rx)
    );
    ldm_mul #(.SHIFT(28)) u_mul_p1ry (
        .clk(clk), .en(adv), .a(from_s32(tangential_reg[63:32])), .b(ry_reg), .p(p1ry)
    );

    // Align normalized coordinates with the radial factor and tangential terms with the sums they join.
    ldm_delay #(.W(FX_W), .DEPTH(S_RAD - S_XU)) u_dly_xu (
        .clk(clk), .en(adv), .d(xu), .q(xu_d)
    );
    ldm_delay #(.W(FX_W), .DEPTH(S_RAD - S_XU)) u_dly_yu (
        .clk(clk), .en(adv), .d(yu), .q(yu_d)
    );
    ldm_delay #(.W(FX_W), .DEPTH(S_XT - S_TP1)) u_dly_p1xy (
        .clk(clk), .en(adv), .d(p1xy), .q(p1xy_d)
    );
    ldm_delay #(.W(FX_W), .DEPTH(S_XT - S_TP1)) u_dly_p2xy (
        .clk(clk), .en(adv), .d(p2xy), .q(p2xy_d)
    );
    ldm_delay #(.W(FX_W), .DEPTH(S_D1 - S_TP2)) u_dly_p2rx (
        .clk(clk), .en(adv), .d(p2rx), .q(p2rx_d)
    );
    ldm_delay #(.W(FX_W), .DEPTH(S_D1 - S_TP2)) u_dly_p1ry (
        .clk(clk), .en(adv), .d(p1ry), .q(p1ry_d)
    );

    ldm_mul #(.SHIFT(28)) u_mul_xt (.clk(clk), .en(adv), .a(xu_d), .b(rad_reg), .p(mxt));
    ldm_mul #(.SHIFT(28)) u_mul_yt (.clk(clk), .en(adv), .a(yu_d), .b(rad_reg), .p(myt));

    // Distorted normalized coordinates, summed in the fixed order.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xd1_reg <= sat_add(mxt, p1xy_d);
            yd1_reg <= sat_add(myt, p2xy_d);
            xd_reg  <= sat_add(xd1_reg, p2rx_d);
            yd_reg  <= sat_add(yd1_reg, p1ry_d);
        end
    end

    // Reproject with the original intrinsics.
    ldm_mul #(.SHIFT(28)) u_mul_px (
        .clk(clk), .en(adv), .a(xd_reg), .b(from_u32(orig_focal_reg[63:32])), .p(pxm)
    );
    ldm_mul #(.SHIFT(28)) u_mul_py (
        .clk(clk), .en(adv), .a(yd_reg), .b(from_u32(orig_focal_reg[31:0])), .p(pym)
    );

    // Final 32-bit saturation and flag merge.
    always_comb
    begin
        logic signed [VAL_W-1:0] ox;
        logic signed [VAL_W-1:0] oy;
        logic                    cx;
        logic                    cy;
        ox = mx_reg.val;
        oy = my_reg.val;
        cx = 1'b0;
        cy = 1'b0;
        if (ox > $signed(VAL_W'(32'sh7FFF_FFFF)))
        begin
            ox = VAL_W'(32'sh7FFF_FFFF);
            cx = 1'b1;
        end
        else if (ox < $signed({{(VAL_W-32){1'b1}}, 32'h8000_0000}))
        begin
            ox = {{(VAL_W-32){1'b1}}, 32'h8000_0000};
            cx = 1'b1;
        end
        if (oy > $signed(VAL_W'(32'sh7FFF_FFFF)))
        begin
            oy = VAL_W'(32'sh7FFF_FFFF);
            cy = 1'b1;
        end
        else if (oy < $signed({{(VAL_W-32){1'b1}}, 32'h8000_0000}))
        begin
            oy = {{(VAL_W-32){1'b1}}, 32'h8000_0000};
            cy = 1'b1;
        end
        last_next.x = ox[31:0];
        last_next.y = oy[31:0];
        last_next.c = mx_reg.flag | my_reg.flag | cx | cy;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg   <= sat_add(pxm, from_s32(orig_center_reg[63:32]));
            my_reg   <= sat_add(pym, from_s32(orig_center_reg[31:0]));
            last_reg <= last_next;
        end
    end

    // Output register with a one-entry skid buffer behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (v_reg[S_LAST])
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (v_reg[S_LAST])
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= last_reg;
            end
            else
            begin
                out_reg <= last_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign map_x     = out_reg.x;
    assign map_y     = out_reg.y;
    assign clipped   = out_reg.c;

    // The skid buffer only fills behind a waiting output.
    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid buffer holds a result while the output register is empty");

    // A finished result that meets a stalled output is parked, not dropped.
    a_stall_parks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (adv && v_reg[S_LAST] && out_valid_reg && !out_ready) |=> skid_valid_reg
    ) else $error("result reached a stalled output without entering the skid buffer");

    // A held pipeline keeps every item where it is.
    a_hold_keeps_items: assert property (
        @(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg)
    ) else $error("pipeline occupancy changed while stalled");

endmodule
